@@ hdl/tca_pkg.sv @@
// shared types and constants of the tick catch-up accounting unit
// used by every module of the block; no dependencies
package tca_pkg;

  localparam int unsigned TimeW    = 64;
  localparam int unsigned TickW    = 32;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned CpuW     = 8;
  localparam int unsigned CpuShift = 12;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = 3;

  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(40960000);
  localparam logic [CpuW-1:0]    CpuReset    = '0;
  localparam logic [TickW-1:0]   TickSat     = '1;

  // register index, taken from paddr[2]
  localparam logic RegPeriod = 1'b0;
  localparam logic RegCpu    = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_LAG,
    CMD_EARLY,
    CMD_LONE,
    CMD_DIVL,
    CMD_TAKEL,
    CMD_MULL,
    CMD_ADVL,
    CMD_GAP,
    CMD_GONE,
    CMD_DIVG,
    CMD_TAKEG,
    CMD_MULG,
    CMD_ADVG,
    CMD_OUT
  } tca_cmd_e;

  typedef struct packed {
    logic op;
    logic early;
    logic lag_small;
    logic above;
    logic gap_big;
    logic div_done;
  } tca_status_t;

endpackage

@@ hdl/tca_div.sv @@
// iterative 64-by-32 divider, one quotient bit per cycle, flags a saturated quotient
// depends on tca_pkg
module tca_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tca_pkg::TimeW-1:0]       num_i,
  input  logic [tca_pkg::PeriodW-1:0]     den_i,
  output logic                            done_o,
  output logic [tca_pkg::TickW-1:0]       quot_o,
  output logic                            sat_o
);

  localparam int unsigned CntW = $clog2(tca_pkg::TimeW);
  localparam logic [CntW-1:0] CntLast = CntW'(tca_pkg::TimeW - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [tca_pkg::PeriodW-1:0]   rem_q, rem_d;
  logic [tca_pkg::PeriodW-1:0]   den_q, den_d;
  logic [tca_pkg::TimeW-1:0]     num_q, num_d;
  logic [tca_pkg::TickW-1:0]     quot_q, quot_d;
  logic                          sat_q, sat_d;

  logic [tca_pkg::PeriodW:0]     rem_sh;
  logic [tca_pkg::PeriodW:0]     diff;
  logic                          ge;

  assign rem_sh = {rem_q, num_q[tca_pkg::TimeW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    quot_d = quot_q;
    sat_d  = sat_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      num_d  = num_i;
      quot_d = '0;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[tca_pkg::PeriodW-1:0] : rem_sh[tca_pkg::PeriodW-1:0];
      num_d  = {num_q[tca_pkg::TimeW-2:0], 1'b0};
      quot_d = {quot_q[tca_pkg::TickW-2:0], ge};
      // any quotient bit above bit 31 saturates
      sat_d  = sat_q | quot_q[tca_pkg::TickW-1];
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    sat_q  <= sat_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign sat_o  = sat_q;

endmodule

@@ hdl/tca_datapath.sv @@
// datapath: deadline and global mark, lag and gap, tick counts, result words
// depends on tca_pkg and tca_div
module tca_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tca_pkg::tca_cmd_e             cmd_i,
  output tca_pkg::tca_status_t          status_o,
  input  logic [tca_pkg::PeriodW-1:0]   period_i,
  input  logic [tca_pkg::CpuW-1:0]      cpu_index_i,
  input  logic                          op_i,
  input  logic [tca_pkg::TimeW-1:0]     clock_req_i,
  output logic                          due_o,
  output logic [tca_pkg::TickW-1:0]     local_ticks_o,
  output logic [tca_pkg::TickW-1:0]     global_ticks_o,
  output logic [tca_pkg::TimeW-1:0]     next_compare_o
);

  localparam int unsigned TimeW = tca_pkg::TimeW;
  localparam int unsigned TickW = tca_pkg::TickW;

  logic [TimeW-1:0] deadline_q, deadline_d;
  logic [TimeW-1:0] mark_q, mark_d;

  logic             op_q, op_d;
  logic [TimeW-1:0] clk_q, clk_d;
  logic [TimeW-1:0] lag_q, lag_d;
  logic             early_q, early_d;
  logic [TimeW-1:0] gap_q, gap_d;
  logic             above_q, above_d;
  logic             due_q, due_d;
  logic [TickW-1:0] lt_q, lt_d;
  logic [TickW-1:0] gt_q, gt_d;
  logic [TimeW-1:0] prod_q, prod_d;

  logic             out_due_q, out_due_d;
  logic [TickW-1:0] out_lt_q, out_lt_d;
  logic [TickW-1:0] out_gt_q, out_gt_d;
  logic [TimeW-1:0] out_next_q, out_next_d;

  logic [TimeW-1:0] period_x;
  logic [TimeW-1:0] cpu_off;
  logic [TickW-1:0] mul_a;
  logic [TimeW-1:0] mul_p;

  logic             div_start;
  logic [TimeW-1:0] div_num;
  logic             div_done;
  logic [TickW-1:0] div_quot;
  logic             div_sat;

  assign period_x = {{(TimeW-tca_pkg::PeriodW){1'b0}}, period_i};
  assign cpu_off  = TimeW'(cpu_index_i) << tca_pkg::CpuShift;
  assign mul_a    = (cmd_i == tca_pkg::CMD_MULG) ? gt_q : lt_q;
  assign mul_p    = {{(TimeW-TickW){1'b0}}, mul_a} * period_x;

  assign div_start = (cmd_i == tca_pkg::CMD_DIVL) || (cmd_i == tca_pkg::CMD_DIVG);
  assign div_num   = (cmd_i == tca_pkg::CMD_DIVG) ? gap_q : lag_q;

  tca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (period_i),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .sat_o   (div_sat)
  );

  always_comb begin
    deadline_d = deadline_q;
    mark_d     = mark_q;
    op_d       = op_q;
    clk_d      = clk_q;
    lag_d      = lag_q;
    early_d    = early_q;
    gap_d      = gap_q;
    above_d    = above_q;
    due_d      = due_q;
    lt_d       = lt_q;
    gt_d       = gt_q;
    prod_d     = prod_q;
    out_due_d  = out_due_q;
    out_lt_d   = out_lt_q;
    out_gt_d   = out_gt_q;
    out_next_d = out_next_q;
    unique case (cmd_i)
      tca_pkg::CMD_LOAD: begin
        op_d  = op_i;
        clk_d = clock_req_i;
        due_d = 1'b1;
        lt_d  = '0;
        gt_d  = '0;
      end
      tca_pkg::CMD_START: begin
        deadline_d = clk_q + period_x;
        mark_d     = clk_q + period_x;
      end
      tca_pkg::CMD_LAG: begin
        lag_d   = clk_q - deadline_q;
        early_d = clk_q < deadline_q;
      end
      tca_pkg::CMD_EARLY: due_d = 1'b0;
      tca_pkg::CMD_LONE:  lt_d  = TickW'(1);
      tca_pkg::CMD_TAKEL: begin
        // missed ticks plus the one that is due, held at the limit
        lt_d = (div_sat || (div_quot == tca_pkg::TickSat)) ?
               tca_pkg::TickSat : div_quot + TickW'(1);
      end
      tca_pkg::CMD_MULL:  prod_d     = mul_p;
      tca_pkg::CMD_ADVL:  deadline_d = deadline_q + prod_q;
      tca_pkg::CMD_GAP: begin
        gap_d   = deadline_q - mark_q;
        above_d = deadline_q > mark_q;
      end
      tca_pkg::CMD_GONE: begin
        gt_d   = TickW'(1);
        prod_d = period_x;
      end
      tca_pkg::CMD_TAKEG: gt_d   = div_sat ? tca_pkg::TickSat : div_quot;
      tca_pkg::CMD_MULG:  prod_d = mul_p;
      tca_pkg::CMD_ADVG:  mark_d = mark_q + prod_q;
      tca_pkg::CMD_OUT: begin
        out_due_d  = due_q;
        out_lt_d   = lt_q;
        out_gt_d   = gt_q;
        out_next_d = deadline_q + cpu_off;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      mark_q     <= '0;
    end else begin
      deadline_q <= deadline_d;
      mark_q     <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    clk_q      <= clk_d;
    lag_q      <= lag_d;
    early_q    <= early_d;
    gap_q      <= gap_d;
    above_q    <= above_d;
    due_q      <= due_d;
    lt_q       <= lt_d;
    gt_q       <= gt_d;
    prod_q     <= prod_d;
    out_due_q  <= out_due_d;
    out_lt_q   <= out_lt_d;
    out_gt_q   <= out_gt_d;
    out_next_q <= out_next_d;
  end

  always_comb begin
    status_o.op        = op_q;
    status_o.early     = early_q;
    status_o.lag_small = lag_q < period_x;
    status_o.above     = above_q;
    status_o.gap_big   = gap_q >= {period_x[TimeW-2:0], 1'b0};
    status_o.div_done  = div_done;
  end

  assign due_o          = out_due_q;
  assign local_ticks_o  = out_lt_q;
  assign global_ticks_o = out_gt_q;
  assign next_compare_o = out_next_q;

endmodule

@@ hdl/tca_ctrl.sv @@
// controller: sequences one event through the datapath, owns both handshakes
// depends on tca_pkg
module tca_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  tca_pkg::tca_status_t  status_i,
  output tca_pkg::tca_cmd_e     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CLASS,
    S_WDIVL,
    S_MULL,
    S_ADVL,
    S_GAP,
    S_GCLS,
    S_WDIVG,
    S_MULG,
    S_ADVG,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o = state_q != S_IDLE;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = tca_pkg::CMD_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = tca_pkg::CMD_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.op) begin
          cmd_o   = tca_pkg::CMD_START;
          state_d = S_FINISH;
        end else begin
          cmd_o   = tca_pkg::CMD_LAG;
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (status_i.early) begin
          cmd_o   = tca_pkg::CMD_EARLY;
          state_d = S_FINISH;
        end else if (status_i.lag_small) begin
          cmd_o   = tca_pkg::CMD_LONE;
          state_d = S_MULL;
        end else begin
          cmd_o   = tca_pkg::CMD_DIVL;
          state_d = S_WDIVL;
        end
      end
      S_WDIVL: begin
        if (status_i.div_done) begin
          cmd_o   = tca_pkg::CMD_TAKEL;
          state_d = S_MULL;
        end
      end
      S_MULL: begin
        cmd_o   = tca_pkg::CMD_MULL;
        state_d = S_ADVL;
      end
      S_ADVL: begin
        cmd_o   = tca_pkg::CMD_ADVL;
        state_d = S_GAP;
      end
      S_GAP: begin
        cmd_o   = tca_pkg::CMD_GAP;
        state_d = S_GCLS;
      end
      S_GCLS: begin
        priority if (!status_i.above) begin
          state_d = S_FINISH;
        end else if (status_i.gap_big) begin
          cmd_o   = tca_pkg::CMD_DIVG;
          state_d = S_WDIVG;
        end else begin
          cmd_o   = tca_pkg::CMD_GONE;
          state_d = S_ADVG;
        end
      end
      S_WDIVG: begin
        if (status_i.div_done) begin
          cmd_o   = tca_pkg::CMD_TAKEG;
          state_d = S_MULG;
        end
      end
      S_MULG: begin
        cmd_o   = tca_pkg::CMD_MULG;
        state_d = S_ADVG;
      end
      S_ADVG: begin
        cmd_o   = tca_pkg::CMD_ADVG;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o       = tca_pkg::CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/tick_catchup_accounting_unit.sv @@
// top level of the tick catch-up accounting unit: register port and glue
// depends on tca_pkg, tca_ctrl and tca_datapath (which holds tca_div)
//
//   channel  | direction | handshake              | words
//   ---------+-----------+------------------------+---------------------------------
//   in       | input     | in_valid_i/in_stall_o  | op_i, clock_req_i
//   out      | output    | out_valid_o/out_stall_i| due_o, local_ticks_o,
//            |           |                        | global_ticks_o, next_compare_o
//   regs     | apb       | psel/penable/pready    | period @ 0x0, cpu_index @ 0x4
//
// one event at a time, each opened by load and closed by output: a start adds start,
// an early interrupt lag and early, an interrupt with no missed tick lag, one tick,
// multiply, advance, gap and class, and a single global tick the mark advance; the
// shared bit-serial divider runs for missed local ticks and for a wide global gap
// reset clears deadline and global mark to zero and loads the register defaults
// a new word is taken while a result waits; a stalled result holds only the last step
module tick_catchup_accounting_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [tca_pkg::TimeW-1:0]     clock_req_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          due_o,
  output logic [tca_pkg::TickW-1:0]     local_ticks_o,
  output logic [tca_pkg::TickW-1:0]     global_ticks_o,
  output logic [tca_pkg::TimeW-1:0]     next_compare_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tca_pkg::AddrW-1:0]     paddr,
  input  logic [tca_pkg::DataW-1:0]     pwdata,
  output logic [tca_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  logic [tca_pkg::PeriodW-1:0] period_q, period_d;
  logic [tca_pkg::CpuW-1:0]    cpu_q, cpu_d;
  logic                        reg_wr;
  logic                        reg_idx;

  tca_pkg::tca_cmd_e    cmd;
  tca_pkg::tca_status_t status;

  // no wait states on the register port
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  // word address, byte lanes ignored
  assign reg_idx = paddr[2];

  always_comb begin
    period_d = period_q;
    cpu_d    = cpu_q;
    if (reg_wr) begin
      unique case (reg_idx)
        tca_pkg::RegPeriod: period_d = pwdata[tca_pkg::PeriodW-1:0];
        tca_pkg::RegCpu:    cpu_d    = pwdata[tca_pkg::CpuW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= tca_pkg::PeriodReset;
      cpu_q    <= tca_pkg::CpuReset;
    end else begin
      period_q <= period_d;
      cpu_q    <= cpu_d;
    end
  end

  // read back the addressed register
  assign prdata = (reg_idx == tca_pkg::RegCpu) ?
                  {{(tca_pkg::DataW-tca_pkg::CpuW){1'b0}}, cpu_q} :
                  tca_pkg::DataW'(period_q);

  // sequencer: handshakes and step order
  tca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, timing state and result registers
  tca_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .period_i       (period_q),
    .cpu_index_i    (cpu_q),
    .op_i           (op_i),
    .clock_req_i    (clock_req_i),
    .due_o          (due_o),
    .local_ticks_o  (local_ticks_o),
    .global_ticks_o (global_ticks_o),
    .next_compare_o (next_compare_o)
  );

endmodule
